// ===== hw/rtl/nrc_pkg.sv =====
// Shared types and constants for the NAT rule classifier and rewriter.
`default_nettype none
package nrc_pkg;

    localparam int WORDS_PER_RULE = 12;

    // Item kinds
    localparam logic [2:0] KIND_PACKET = 3'd0;
    localparam logic [2:0] KIND_STAGE  = 3'd1;
    localparam logic [2:0] KIND_ADD    = 3'd2;
    localparam logic [2:0] KIND_DELETE = 3'd3;
    localparam logic [2:0] KIND_FLUSH  = 3'd4;

    // Hook points
    localparam logic [2:0] HOOK_PRE_ROUTING  = 3'd0;
    localparam logic [2:0] HOOK_LOCAL_IN     = 3'd1;
    localparam logic [2:0] HOOK_FORWARD      = 3'd2;
    localparam logic [2:0] HOOK_LOCAL_OUT    = 3'd3;
    localparam logic [2:0] HOOK_POST_ROUTING = 3'd4;

    // Rule types
    localparam logic [31:0] TYPE_SNAT = 32'd0;
    localparam logic [31:0] TYPE_DNAT = 32'd1;
    localparam logic [31:0] TYPE_MASQ = 32'd2;

    // Status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_FULL       = 2'd1;
    localparam logic [1:0] STATUS_NOT_IN_USE = 2'd2;

    // IP protocols with ports
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // Staged word selectors
    localparam logic [3:0] FIELD_PROTO    = 4'd0;
    localparam logic [3:0] FIELD_SRC      = 4'd1;
    localparam logic [3:0] FIELD_SRCMASK  = 4'd2;
    localparam logic [3:0] FIELD_DST      = 4'd3;
    localparam logic [3:0] FIELD_DSTMASK  = 4'd4;
    localparam logic [3:0] FIELD_PORTLO   = 4'd5;
    localparam logic [3:0] FIELD_PORTHI   = 4'd6;
    localparam logic [3:0] FIELD_TYPE     = 4'd7;
    localparam logic [3:0] FIELD_NEWSRC   = 4'd8;
    localparam logic [3:0] FIELD_NEWDST   = 4'd9;
    localparam logic [3:0] FIELD_NEWSPORT = 4'd10;
    localparam logic [3:0] FIELD_NEWDPORT = 4'd11;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  rule_index;
        logic [3:0]  rule_field;
        logic [31:0] rule_value;
        logic [2:0]  hook_point;
        logic [7:0]  protocol;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        rule_hit;
        logic [3:0]  hit_index;
        logic        translated;
        logic [31:0] new_src_ip;
        logic [31:0] new_dst_ip;
        logic [15:0] new_src_port;
        logic [15:0] new_dst_port;
        logic [4:0]  rules_in_use;
    } out_word_t;

    typedef struct packed {
        logic [31:0] proto;
        logic [31:0] src;
        logic [31:0] srcmask;
        logic [31:0] dst;
        logic [31:0] dstmask;
        logic [31:0] portlo;
        logic [31:0] porthi;
        logic [31:0] rtype;
        logic [31:0] newsrc;
        logic [31:0] newdst;
        logic [31:0] newsport;
        logic [31:0] newdport;
    } rule_t;

    // Packet tuple as held during a scan; ports already zeroed off TCP/UDP
    typedef struct packed {
        logic [2:0]  hook_point;
        logic [7:0]  protocol;
        logic        l4;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
    } pkt_t;

    typedef struct packed {
        logic        hit;
        logic        translated;
        logic [31:0] new_src_ip;
        logic [31:0] new_dst_ip;
        logic [15:0] new_src_port;
        logic [15:0] new_dst_port;
    } eval_t;

endpackage
`default_nettype wire

// ===== hw/rtl/nrc_rule_eval.sv =====
// Match test of one rule against a packet tuple and the resulting rewrite.
`default_nettype none
module nrc_rule_eval
    import nrc_pkg::*;
(
    input  wire rule_t rule,
    input  wire pkt_t  pkt,
    output eval_t res
);

    logic [7:0]  rule_proto;
    logic [15:0] port_lo;
    logic [15:0] port_hi;
    logic [15:0] port_hi_eff;
    logic        proto_ok;
    logic        src_ok;
    logic        dst_ok;
    logic        port_ok;
    logic        do_snat;
    logic        do_dnat;
    logic [15:0] new_sport;
    logic [15:0] new_dport;

    // Match tests
    always_comb
    begin
        rule_proto  = rule.proto[7:0];
        port_lo     = rule.portlo[15:0];
        port_hi     = rule.porthi[15:0];
        port_hi_eff = (port_hi == 16'd0) ? port_lo : port_hi;
        proto_ok    = (rule_proto == 8'd0) || (rule_proto == pkt.protocol);
        src_ok      = (pkt.src_ip & rule.srcmask) == (rule.src & rule.srcmask);
        dst_ok      = (pkt.dst_ip & rule.dstmask) == (rule.dst & rule.dstmask);
        port_ok     = ((port_lo == 16'd0) && (port_hi == 16'd0)) ||
                      ((pkt.sport >= port_lo) && (pkt.sport <= port_hi_eff));
    end

    // Rewrite by rule type and hook
    always_comb
    begin
        do_snat = ((rule.rtype == TYPE_SNAT) || (rule.rtype == TYPE_MASQ)) &&
                  ((pkt.hook_point == HOOK_LOCAL_OUT) ||
                   (pkt.hook_point == HOOK_POST_ROUTING));
        do_dnat = (rule.rtype == TYPE_DNAT) &&
                  ((pkt.hook_point == HOOK_PRE_ROUTING) ||
                   (pkt.hook_point == HOOK_LOCAL_IN));
        new_sport = rule.newsport[15:0];
        new_dport = rule.newdport[15:0];

        res.hit          = proto_ok && src_ok && dst_ok && port_ok;
        res.translated   = do_snat || do_dnat;
        res.new_src_ip   = do_snat ? rule.newsrc : pkt.src_ip;
        res.new_dst_ip   = do_dnat ? rule.newdst : pkt.dst_ip;
        res.new_src_port = (do_snat && pkt.l4 && (new_sport != 16'd0)) ? new_sport
                                                                       : pkt.sport;
        res.new_dst_port = (do_dnat && pkt.l4 && (new_dport != 16'd0)) ? new_dport
                                                                       : pkt.dport;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/nat_rule_classifier_rewriter.sv =====
// Top level: first-match NAT rule table with a slot-per-cycle scan of the rule memory.
// Packet: scans from slot 0 to the first valid hit or the last slot (one memory read per slot).
// Add: searches the valid bits one slot per cycle for the first free slot.
// Stage, delete, flush and unknown kinds: result in the cycle after start.
// One item at a time; busy is high while a packet or an add is in progress.
// Reset clears valid bits, count and staged words; rule memory is not cleared.
`default_nettype none
module nat_rule_classifier_rewriter
    import nrc_pkg::*;
#(
    parameter int RULE_SLOTS = 16
)
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             start,
    output logic            busy,
    input  wire in_word_t   cmd,
    output logic            done,
    output out_word_t       result
);

    localparam int SLOT_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(RULE_SLOTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_ADD  = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [RULE_SLOTS-1:0]   valid_reg, valid_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [31:0]             staged_reg [WORDS_PER_RULE];
    pkt_t                    pkt_reg, pkt_next;
    out_word_t               out_reg, out_next;
    logic                    done_reg, done_next;

    rule_t                   rule_mem [RULE_SLOTS];
    rule_t                   rd_rule;
    rule_t                   staged_rule;
    logic                    mem_re;
    logic                    mem_we;
    logic [SLOT_W-1:0]       rd_slot;

    eval_t                   eval;
    logic                    accept;
    logic                    last_slot;
    logic [SLOT_W-1:0]       slot_inc;
    logic [SLOT_W+3:0]       slot_ext;
    logic [SLOT_W+3:0]       idx_ext;
    logic [CNT_W+4:0]        cnt_ext;
    logic                    l4_in;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = out_reg;
    assign last_slot = (slot_reg == SLOT_W'(RULE_SLOTS - 1));
    assign slot_inc  = slot_reg + 1'b1;
    assign slot_ext  = {4'd0, slot_reg};
    assign idx_ext   = {{SLOT_W{1'b0}}, cmd.rule_index};
    assign cnt_ext   = {5'd0, cnt_next};
    assign l4_in     = (cmd.protocol == PROTO_TCP) || (cmd.protocol == PROTO_UDP);

    // Assemble the staged rule from the staging words
    always_comb
    begin
        staged_rule.proto    = staged_reg[FIELD_PROTO];
        staged_rule.src      = staged_reg[FIELD_SRC];
        staged_rule.srcmask  = staged_reg[FIELD_SRCMASK];
        staged_rule.dst      = staged_reg[FIELD_DST];
        staged_rule.dstmask  = staged_reg[FIELD_DSTMASK];
        staged_rule.portlo   = staged_reg[FIELD_PORTLO];
        staged_rule.porthi   = staged_reg[FIELD_PORTHI];
        staged_rule.rtype    = staged_reg[FIELD_TYPE];
        staged_rule.newsrc   = staged_reg[FIELD_NEWSRC];
        staged_rule.newdst   = staged_reg[FIELD_NEWDST];
        staged_rule.newsport = staged_reg[FIELD_NEWSPORT];
        staged_rule.newdport = staged_reg[FIELD_NEWDPORT];
    end

    // Evaluate the rule read in the previous cycle
    nrc_rule_eval u_eval (
        .rule (rd_rule),
        .pkt  (pkt_reg),
        .res  (eval)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        slot_next  = slot_reg;
        pkt_next   = pkt_reg;
        out_next   = out_reg;
        done_next  = 1'b0;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        rd_slot    = slot_inc;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_next          = '0;
                    out_next.status   = STATUS_OK;
                    priority if (cmd.kind == KIND_PACKET)
                    begin
                        // Latch tuple, read slot 0
                        pkt_next.hook_point = cmd.hook_point;
                        pkt_next.protocol   = cmd.protocol;
                        pkt_next.l4         = l4_in;
                        pkt_next.src_ip     = cmd.src_ip;
                        pkt_next.dst_ip     = cmd.dst_ip;
                        pkt_next.sport      = l4_in ? cmd.sport : 16'd0;
                        pkt_next.dport      = l4_in ? cmd.dport : 16'd0;
                        mem_re     = 1'b1;
                        rd_slot    = '0;
                        slot_next  = '0;
                        state_next = ST_SCAN;
                    end
                    else if (cmd.kind == KIND_ADD)
                    begin
                        slot_next  = '0;
                        state_next = ST_ADD;
                    end
                    else
                    begin
                        if (cmd.kind == KIND_DELETE)
                        begin
                            if ((idx_ext < (SLOT_W + 4)'(RULE_SLOTS)) &&
                                valid_reg[idx_ext[SLOT_W-1:0]])
                            begin
                                valid_next[idx_ext[SLOT_W-1:0]] = 1'b0;
                                cnt_next = cnt_reg - 1'b1;
                            end
                            else
                            begin
                                out_next.status = STATUS_NOT_IN_USE;
                            end
                        end
                        else if (cmd.kind == KIND_FLUSH)
                        begin
                            valid_next = '0;
                            cnt_next   = '0;
                        end
                        out_next.rules_in_use = cnt_ext[4:0];
                        done_next = 1'b1;
                    end
                end
            end

            ST_SCAN:
            begin
                // Check one slot, prefetch the next
                if ((valid_reg[slot_reg] && eval.hit) || last_slot)
                begin
                    out_next.rule_hit     = 1'b0;
                    out_next.hit_index    = 4'd0;
                    out_next.translated   = 1'b0;
                    out_next.new_src_ip   = pkt_reg.src_ip;
                    out_next.new_dst_ip   = pkt_reg.dst_ip;
                    out_next.new_src_port = pkt_reg.sport;
                    out_next.new_dst_port = pkt_reg.dport;
                    if (valid_reg[slot_reg] && eval.hit)
                    begin
                        out_next.rule_hit     = 1'b1;
                        out_next.hit_index    = slot_ext[3:0];
                        out_next.translated   = eval.translated;
                        out_next.new_src_ip   = eval.new_src_ip;
                        out_next.new_dst_ip   = eval.new_dst_ip;
                        out_next.new_src_port = eval.new_src_port;
                        out_next.new_dst_port = eval.new_dst_port;
                    end
                    out_next.rules_in_use = cnt_ext[4:0];
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    slot_next = slot_inc;
                end
            end

            ST_ADD:
            begin
                // Search the first free slot and write the staged rule there
                if (!valid_reg[slot_reg])
                begin
                    mem_we               = 1'b1;
                    valid_next[slot_reg] = 1'b1;
                    cnt_next             = cnt_reg + 1'b1;
                    out_next.hit_index   = slot_ext[3:0];
                    out_next.rules_in_use = cnt_ext[4:0];
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (last_slot)
                begin
                    out_next.status       = STATUS_FULL;
                    out_next.rules_in_use = cnt_ext[4:0];
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    slot_next = slot_inc;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Rule memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rule_mem[slot_reg] <= staged_rule;
        end
        if (mem_re)
        begin
            rd_rule <= rule_mem[rd_slot];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            for (int i = 0; i < WORDS_PER_RULE; i++)
            begin
                staged_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            if (accept && (cmd.kind == KIND_STAGE) &&
                (cmd.rule_field < 4'(WORDS_PER_RULE)))
            begin
                staged_reg[cmd.rule_field] <= cmd.rule_value;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        pkt_reg  <= pkt_next;
        out_reg  <= out_next;
    end

    // Count tracks the valid bits
    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cnt_reg) == 32'($countones(valid_reg))))
        else $error("valid count differs from valid bits");

    // A translation only comes with a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && out_reg.translated) |-> out_reg.rule_hit)
        else $error("translated without a rule hit");

    // An accepted item keeps the block busy or completes next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy || done_reg))
        else $error("accepted item vanished");

    // No result while an item is still in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg |-> (state_reg == ST_IDLE) || $past(state_reg == ST_IDLE)))
        else $error("result strobe inside a scan");

    // Add never reports a slot it did not fill
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_ADD) && !valid_reg[slot_reg]) |=> valid_reg[$past(slot_reg)])
        else $error("add did not mark its slot valid");

endmodule
`default_nettype wire

// ===== tb/sv/nat_rule_classifier_rewriter_tb.sv =====
// Testbench for the NAT rule classifier and rewriter: random and directed words.
`default_nettype none
module nat_rule_classifier_rewriter_tb
    import nrc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;

    // Predictor of the rule table and queue of expected result words
    class nat_scoreboard;
        rule_t     table_q[SLOTS];
        bit        slot_valid[SLOTS];
        rule_t     staged;
        int        in_use;
        out_word_t pending[$];
        int        errors;

        function void clear();
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_valid[i] = 0;
                table_q[i] = '0;
            end
            staged = '0;
            in_use = 0;
            errors = 0;
        endfunction

        function bit rule_matches(rule_t r, logic [7:0] proto, logic [31:0] s,
                                  logic [31:0] d, logic [15:0] sp);
            logic [15:0] lo;
            logic [15:0] hi;
            lo = r.portlo[15:0];
            hi = r.porthi[15:0];
            if (r.proto[7:0] != 0 && r.proto[7:0] != proto) return 0;
            if ((s & r.srcmask) != (r.src & r.srcmask)) return 0;
            if ((d & r.dstmask) != (r.dst & r.dstmask)) return 0;
            if (lo != 0 || hi != 0)
            begin
                if (hi == 0) hi = lo;
                if (sp < lo || sp > hi) return 0;
            end
            return 1;
        endfunction

        // Apply one accepted word and queue the result it should produce
        function void note_input(in_word_t c);
            out_word_t o;
            bit l4;
            rule_t r;
            o = '0;
            case (c.kind)
                KIND_PACKET:
                begin
                    l4 = (c.protocol == PROTO_TCP || c.protocol == PROTO_UDP);
                    o.new_src_ip = c.src_ip;
                    o.new_dst_ip = c.dst_ip;
                    o.new_src_port = l4 ? c.sport : 16'd0;
                    o.new_dst_port = l4 ? c.dport : 16'd0;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        r = table_q[i];
                        if (slot_valid[i] && rule_matches(r, c.protocol, c.src_ip,
                                                          c.dst_ip, o.new_src_port))
                        begin
                            o.rule_hit = 1;
                            o.hit_index = 4'(i);
                            if ((r.rtype == TYPE_SNAT || r.rtype == TYPE_MASQ) &&
                                (c.hook_point == HOOK_LOCAL_OUT ||
                                 c.hook_point == HOOK_POST_ROUTING))
                            begin
                                o.new_src_ip = r.newsrc;
                                if (l4 && r.newsport[15:0] != 0)
                                    o.new_src_port = r.newsport[15:0];
                                o.translated = 1;
                            end
                            else if (r.rtype == TYPE_DNAT &&
                                     (c.hook_point == HOOK_PRE_ROUTING ||
                                      c.hook_point == HOOK_LOCAL_IN))
                            begin
                                o.new_dst_ip = r.newdst;
                                if (l4 && r.newdport[15:0] != 0)
                                    o.new_dst_port = r.newdport[15:0];
                                o.translated = 1;
                            end
                            break;
                        end
                    end
                end
                KIND_STAGE:
                begin
                    if (c.rule_field < WORDS_PER_RULE)
                        staged[(11 - c.rule_field) * 32 +: 32] = c.rule_value;
                end
                KIND_ADD:
                begin
                    o.status = STATUS_FULL;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!slot_valid[i])
                        begin
                            table_q[i] = staged;
                            slot_valid[i] = 1;
                            in_use++;
                            o.hit_index = 4'(i);
                            o.status = STATUS_OK;
                            break;
                        end
                    end
                end
                KIND_DELETE:
                begin
                    if (slot_valid[c.rule_index])
                    begin
                        slot_valid[c.rule_index] = 0;
                        in_use--;
                    end
                    else
                        o.status = STATUS_NOT_IN_USE;
                end
                KIND_FLUSH:
                begin
                    for (int i = 0; i < SLOTS; i++) slot_valid[i] = 0;
                    in_use = 0;
                end
                default: ;
            endcase
            o.rules_in_use = 5'(in_use);
            pending.push_back(o);
        endfunction

        // Compare one result word against the oldest expectation
        function void check_result(out_word_t a);
            out_word_t e;
            if (pending.size() == 0)
            begin
                $error("result word with nothing expected: %h", a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status)
            begin
                $error("status exp %0d got %0d", e.status, a.status); errors++;
            end
            if (a.rule_hit !== e.rule_hit)
            begin
                $error("rule_hit exp %0d got %0d", e.rule_hit, a.rule_hit); errors++;
            end
            if (a.hit_index !== e.hit_index)
            begin
                $error("hit_index exp %0d got %0d", e.hit_index, a.hit_index); errors++;
            end
            if (a.translated !== e.translated)
            begin
                $error("translated exp %0d got %0d", e.translated, a.translated);
                errors++;
            end
            if (a.new_src_ip !== e.new_src_ip)
            begin
                $error("new_src_ip exp %h got %h", e.new_src_ip, a.new_src_ip); errors++;
            end
            if (a.new_dst_ip !== e.new_dst_ip)
            begin
                $error("new_dst_ip exp %h got %h", e.new_dst_ip, a.new_dst_ip); errors++;
            end
            if (a.new_src_port !== e.new_src_port)
            begin
                $error("new_src_port exp %h got %h", e.new_src_port, a.new_src_port);
                errors++;
            end
            if (a.new_dst_port !== e.new_dst_port)
            begin
                $error("new_dst_port exp %h got %h", e.new_dst_port, a.new_dst_port);
                errors++;
            end
            if (a.rules_in_use !== e.rules_in_use)
            begin
                $error("rules_in_use exp %0d got %0d", e.rules_in_use, a.rules_in_use);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_word_t  cmd;
    logic      done;
    out_word_t result;

    nat_scoreboard sb;
    int  gap_pct;
    longint cycles;

    nat_rule_classifier_rewriter #(.RULE_SLOTS(SLOTS)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .done(done), .result(result)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Check each result word at the edge that ends its strobe cycle
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result(result);
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("nat_rule_classifier_rewriter_tb: done, errors");
            $finish;
        end
    end

    // Drive one word: random idle first, then hold start until accepted
    task automatic send(in_word_t c);
        bit acc;
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 0;
            @(posedge clk);
        end
        start <= 1;
        cmd <= c;
        // Sample busy mid-cycle; it only moves at rising edges
        forever
        begin
            @(negedge clk);
            acc = !busy;
            @(posedge clk);
            if (acc) break;
        end
        sb.note_input(c);
    endtask

    function automatic in_word_t rand_word();
        in_word_t c;
        c = in_word_t'($bits(in_word_t)'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        return c;
    endfunction

    function automatic in_word_t ctl(logic [2:0] k, logic [3:0] f, logic [31:0] v);
        in_word_t c;
        c = rand_word();
        c.kind = k;
        c.rule_field = f;
        c.rule_value = v;
        c.rule_index = f;
        return c;
    endfunction

    function automatic in_word_t pkt(logic [2:0] hook, logic [7:0] p, logic [31:0] s,
                                     logic [31:0] d, logic [15:0] sp, logic [15:0] dp);
        in_word_t c;
        c = rand_word();
        c.kind = KIND_PACKET;
        c.hook_point = hook;
        c.protocol = p;
        c.src_ip = s;
        c.dst_ip = d;
        c.sport = sp;
        c.dport = dp;
        return c;
    endfunction

    // Stage and add a rule with a small pool of addresses so packets hit
    task automatic add_rule(bit wide);
        logic [7:0] p;
        logic [15:0] lo;
        int r;
        r = $urandom_range(3);
        p = (r == 0) ? 8'd0 : (r == 1) ? PROTO_TCP : (r == 2) ? PROTO_UDP : 8'($urandom);
        send(ctl(KIND_STAGE, FIELD_PROTO, {$urandom_range(1) ? 24'($urandom) : 24'd0, p}));
        send(ctl(KIND_STAGE, FIELD_SRC, {8'd10, 22'd0, 2'($urandom)}));
        send(ctl(KIND_STAGE, FIELD_SRCMASK, wide ? 32'hFF000000 : 32'hFFFFFFFF));
        send(ctl(KIND_STAGE, FIELD_DST, {8'd20, 22'd0, 2'($urandom)}));
        send(ctl(KIND_STAGE, FIELD_DSTMASK, $urandom_range(1) ? 32'hFFFFFF00 : 32'h0));
        lo = $urandom_range(2) == 0 ? 16'd0 : 16'($urandom_range(0, 40));
        send(ctl(KIND_STAGE, FIELD_PORTLO, {16'($urandom), lo}));
        send(ctl(KIND_STAGE, FIELD_PORTHI,
                 {16'($urandom), $urandom_range(1) ? 16'd0 : lo + 16'($urandom_range(20))}));
        send(ctl(KIND_STAGE, FIELD_TYPE, $urandom_range(9) == 0 ? $urandom : $urandom_range(2)));
        send(ctl(KIND_STAGE, FIELD_NEWSRC, $urandom));
        send(ctl(KIND_STAGE, FIELD_NEWDST, $urandom));
        send(ctl(KIND_STAGE, FIELD_NEWSPORT, $urandom_range(1) ? 32'($urandom) : 32'd0));
        send(ctl(KIND_STAGE, FIELD_NEWDPORT, $urandom_range(1) ? 32'($urandom) : 32'd0));
        send(ctl(KIND_ADD, 4'd0, 32'd0));
    endtask

    task automatic rand_packet();
        logic [7:0] p;
        int r;
        r = $urandom_range(3);
        p = (r == 0) ? PROTO_TCP : (r == 1) ? PROTO_UDP : 8'($urandom);
        if ($urandom_range(4) == 0)
            send(pkt(3'($urandom), p, $urandom, $urandom, 16'($urandom), 16'($urandom)));
        else
            send(pkt(3'($urandom_range(4)), p, {8'd10, 22'($urandom_range(3)), 2'($urandom)},
                     {8'd20, 22'($urandom_range(1)), 2'($urandom)},
                     $urandom_range(1) ? 16'($urandom_range(64)) : 16'($urandom),
                     16'($urandom)));
    endtask

    // Drop start and hold off until every expected result has come
    task automatic wait_drain();
        start <= 0;
        do
            @(posedge clk);
        while (sb.pending.size() != 0);
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        cycles = 0;
        gap_pct = 0;
        rst_n = 0;
        start = 0;
        cmd = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: empty table, bad selector, bad delete, unknown kind
        send(pkt(HOOK_PRE_ROUTING, PROTO_TCP, 32'hFFFFFFFF, 32'h0, 16'hFFFF, 16'h0));
        send(ctl(KIND_STAGE, 4'd15, 32'hFFFFFFFF));
        send(ctl(KIND_DELETE, 4'd15, 32'd0));
        send(ctl(3'd7, 4'd0, 32'd0));
        send(ctl(3'd5, 4'd0, 32'd0));
        // Directed: fill table past full, then exercise hits, delete, flush
        for (int i = 0; i < SLOTS; i++)
            add_rule(i[0]);
        send(ctl(KIND_ADD, 4'd0, 32'd0));
        send(pkt(HOOK_POST_ROUTING, PROTO_UDP, 32'h0A000001, 32'h14000001, 16'd5, 16'd9));
        send(pkt(HOOK_FORWARD, 8'd1, 32'h0A000000, 32'h14000000, 16'hFFFF, 16'hFFFF));
        send(ctl(KIND_DELETE, 4'd0, 32'd0));
        send(ctl(KIND_DELETE, 4'd0, 32'd0));
        send(ctl(KIND_FLUSH, 4'd0, 32'd0));
        wait_drain();

        // Random phases: sender idles 37%, then 83%, then never
        for (int ph = 0; ph < 3; ph++)
        begin
            gap_pct = (ph == 0) ? 37 : (ph == 1) ? 83 : 0;
            for (int n = 0; n < 70; n++)
            begin
                int r;
                r = $urandom_range(99);
                if (r < 35) rand_packet();
                else if (r < 40) add_rule(1'($urandom_range(1)));
                else if (r < 55) send(ctl(KIND_STAGE, 4'($urandom), $urandom));
                else if (r < 65) send(ctl(KIND_ADD, 4'd0, 32'd0));
                else if (r < 78) send(ctl(KIND_DELETE, 4'($urandom), 32'd0));
                else if (r < 81) send(ctl(KIND_FLUSH, 4'd0, 32'd0));
                else if (r < 83) send(ctl(3'($urandom_range(5, 7)), 4'd0, 32'd0));
                else rand_packet();
            end
            // Pause until every result has come
            wait_drain();
        end

        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("nat_rule_classifier_rewriter_tb: done, clean");
        else
            $display("nat_rule_classifier_rewriter_tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
